>>> rtl/tmtw_pkg.sv
// tmtw_pkg: shared constants, codes and controller/datapath handshake types
// for the text mode terminal writer; no dependencies
`default_nettype none

package tmtw_pkg;

  // screen geometry defaults
  localparam int ROWS_DEF = 25;
  localparam int COLS_DEF = 80;

  // fixed field widths
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = CHAR_W + ATTR_W;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // character and attribute constants
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [ATTR_W-1:0] FILL_RESET   = 8'h07;

  // blank write source
  typedef enum logic [1:0] {
    W_NONE,
    W_FILL,
    W_INIT
  } wsel_t;

  typedef struct packed {
    logic  capture;
    logic  put_step;
    logic  copy_rd;
    logic  read_cap;
    logic  home;
    logic  out_load;
    logic  idx_zero;
    logic  idx_inc;
    wsel_t wsel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic put_scroll;
    logic idx_last_copy;
    logic idx_last_cell;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/tmtw_channels.sv
// tmtw_in_if / tmtw_out_if: valid/ready channels for command and result beats
// depends on tmtw_pkg for field widths
`default_nettype none

interface tmtw_in_if;
  logic                         valid;
  logic                         ready;
  logic [tmtw_pkg::CMD_W-1:0]   command;
  logic [tmtw_pkg::CHAR_W-1:0]  char_code;
  logic [tmtw_pkg::ATTR_W-1:0]  attribute;
  logic [tmtw_pkg::ROW_W-1:0]   read_row;
  logic [tmtw_pkg::COL_W-1:0]   read_col;

  modport source (output valid, command, char_code, attribute, read_row, read_col,
                  input ready);
  modport sink (input valid, command, char_code, attribute, read_row, read_col,
                output ready);
endinterface

interface tmtw_out_if;
  logic                         valid;
  logic                         ready;
  logic [tmtw_pkg::ROW_W-1:0]   cursor_row_out;
  logic [tmtw_pkg::COL_W-1:0]   cursor_col_out;
  logic                         scrolled;
  logic [tmtw_pkg::CHAR_W-1:0]  cell_char;
  logic [tmtw_pkg::ATTR_W-1:0]  cell_attribute;

  modport source (output valid, cursor_row_out, cursor_col_out, scrolled, cell_char,
                  cell_attribute, input ready);
  modport sink (input valid, cursor_row_out, cursor_col_out, scrolled, cell_char,
                cell_attribute, output ready);
endinterface

`default_nettype wire

>>> rtl/text_mode_terminal_writer_unit.sv
// text_mode_terminal_writer_unit: top level of the text mode terminal writer
// depends on tmtw_pkg, tmtw_in_if/tmtw_out_if, tmtw_ctrl, tmtw_datapath
`default_nettype none

// channel   | dir | handshake     | beat contents
// ----------+-----+---------------+-----------------------------------------------
// in_ch     | in  | valid/ready   | command, char_code, attribute, read_row, read_col
// out_ch    | out | valid/ready   | cursor_row_out, cursor_col_out, scrolled,
//           |     |               | cell_char, cell_attribute
// cfg       | in  | cfg_wr_en     | cfg_wr_data = fill attribute
//
// one command beat at a time; from accept to result ready the sequencer runs:
//   put: cell write unless newline; read: address, then capture; unused code: none;
//   clear: sweep of every cell; scrolling put: copy rows up, then blank the last row
// the single-port-write cell memory sets the sweep lengths: one cell per cycle
// after reset a fill sweep of every cell runs before the first beat
// a result waits in the output register; the next command is taken meanwhile and
// only its own result waits for out_ch.ready

module text_mode_terminal_writer_unit #(
  parameter int ROWS = tmtw_pkg::ROWS_DEF,
  parameter int COLS = tmtw_pkg::COLS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  tmtw_in_if.sink                          in_ch,
  tmtw_out_if.source                       out_ch,
  input  wire logic                        cfg_wr_en,
  input  wire logic [tmtw_pkg::ATTR_W-1:0] cfg_wr_data
);

  // command/status between sequencer and datapath
  tmtw_pkg::ctrl_cmd_t  cmd;
  tmtw_pkg::dp_status_t status;

  // sequencer: init sweep, command dispatch, sweeps, result handoff
  tmtw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .status     (status),
    .cmd        (cmd)
  );

  // cell store, cursor, fill attribute and output register
  tmtw_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_char_code       (in_ch.char_code),
    .in_attribute       (in_ch.attribute),
    .in_read_row        (in_ch.read_row),
    .in_read_col        (in_ch.read_col),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_cursor_row     (out_ch.cursor_row_out),
    .out_cursor_col     (out_ch.cursor_col_out),
    .out_scrolled       (out_ch.scrolled),
    .out_cell_char      (out_ch.cell_char),
    .out_cell_attribute (out_ch.cell_attribute)
  );

endmodule

`default_nettype wire

>>> rtl/tmtw_ctrl.sv
// tmtw_ctrl: sequencing state machine for put, clear, scroll, read and init sweep
// depends on tmtw_pkg for command codes and control/status structs
`default_nettype none

module tmtw_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic [tmtw_pkg::CMD_W-1:0] in_command,
  output logic                            in_ready,
  input  wire tmtw_pkg::dp_status_t       status,
  output tmtw_pkg::ctrl_cmd_t             cmd
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_PUT,
    S_COPY,
    S_COPY_END,
    S_BLANK,
    S_CLEAR,
    S_READ,
    S_READ_CAP,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.wsel   = tmtw_pkg::W_NONE;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.wsel    = tmtw_pkg::W_INIT;
        cmd.idx_inc = 1'b1;
        if (status.idx_last_cell) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.capture  = 1'b1;
          cmd.idx_zero = 1'b1;
          case (in_command)
            tmtw_pkg::CMD_PUT:   state_next = S_PUT;
            tmtw_pkg::CMD_CLEAR: state_next = S_CLEAR;
            tmtw_pkg::CMD_READ:  state_next = S_READ;
            default:             state_next = S_DONE;
          endcase
        end
      end
      S_PUT: begin
        cmd.put_step = 1'b1;
        state_next   = status.put_scroll ? S_COPY : S_DONE;
      end
      S_COPY: begin
        // read the cell one row below; it is written back in the following cycle
        cmd.copy_rd = 1'b1;
        cmd.idx_inc = 1'b1;
        if (status.idx_last_copy) begin
          state_next = S_COPY_END;
        end
      end
      S_COPY_END: begin
        // last pending copy write drains here
        state_next = S_BLANK;
      end
      S_BLANK: begin
        cmd.wsel    = tmtw_pkg::W_FILL;
        cmd.idx_inc = 1'b1;
        if (status.idx_last_cell) begin
          state_next = S_DONE;
        end
      end
      S_CLEAR: begin
        cmd.wsel    = tmtw_pkg::W_FILL;
        cmd.home    = 1'b1;
        cmd.idx_inc = 1'b1;
        if (status.idx_last_cell) begin
          state_next = S_DONE;
        end
      end
      S_READ: begin
        state_next = S_READ_CAP;
      end
      S_READ_CAP: begin
        cmd.read_cap = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      in_ready <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule

`default_nettype wire

>>> rtl/tmtw_datapath.sv
// tmtw_datapath: cell store memory, cursor, sweep counter, fill register and
// result register; depends on tmtw_pkg
`default_nettype none

module tmtw_datapath #(
  parameter int ROWS = tmtw_pkg::ROWS_DEF,
  parameter int COLS = tmtw_pkg::COLS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire tmtw_pkg::ctrl_cmd_t         cmd,
  output tmtw_pkg::dp_status_t             status,
  input  wire logic                        cfg_wr_en,
  input  wire logic [tmtw_pkg::ATTR_W-1:0] cfg_wr_data,
  input  wire logic [tmtw_pkg::CHAR_W-1:0] in_char_code,
  input  wire logic [tmtw_pkg::ATTR_W-1:0] in_attribute,
  input  wire logic [tmtw_pkg::ROW_W-1:0]  in_read_row,
  input  wire logic [tmtw_pkg::COL_W-1:0]  in_read_col,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic [tmtw_pkg::ROW_W-1:0]       out_cursor_row,
  output logic [tmtw_pkg::COL_W-1:0]       out_cursor_col,
  output logic                             out_scrolled,
  output logic [tmtw_pkg::CHAR_W-1:0]      out_cell_char,
  output logic [tmtw_pkg::ATTR_W-1:0]      out_cell_attribute
);

  localparam int CELLS = ROWS * COLS;
  localparam int COPY_N = (ROWS - 1) * COLS;
  localparam int AW = $clog2(CELLS);
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);

  // cell store, {char, attribute}
  logic [tmtw_pkg::CELL_W-1:0] mem [CELLS];
  logic [tmtw_pkg::CELL_W-1:0] rdata;
  logic [AW-1:0]               raddr;
  logic                        we;
  logic [AW-1:0]               waddr;
  logic [tmtw_pkg::CELL_W-1:0] wdata;

  logic [RW-1:0]               row_pos;
  logic [CW-1:0]               col_pos;
  logic [AW-1:0]               idx;
  logic                        wr_pend;
  logic [AW-1:0]               wr_addr;
  logic [tmtw_pkg::ATTR_W-1:0] fill;

  logic [tmtw_pkg::CHAR_W-1:0] char_q;
  logic [tmtw_pkg::ATTR_W-1:0] attr_q;
  logic [tmtw_pkg::ROW_W-1:0]  rd_row_q;
  logic [tmtw_pkg::COL_W-1:0]  rd_col_q;
  logic                        scrolled_q;
  logic [tmtw_pkg::CELL_W-1:0] cell_q;

  logic                        is_nl;
  logic [CW:0]                 col_inc;
  logic [RW:0]                 row_inc;
  logic                        wrap;
  logic                        need_scroll;
  logic [AW-1:0]               put_pos;
  logic [AW-1:0]               read_pos;
  logic                        read_ok;
  logic [31:0]                 row_ext;
  logic [31:0]                 col_ext;

  // cursor step
  assign is_nl       = (char_q == tmtw_pkg::CHAR_NEWLINE);
  assign col_inc     = {1'b0, col_pos} + (CW+1)'(1);
  assign row_inc     = {1'b0, row_pos} + (RW+1)'(1);
  assign wrap        = is_nl || (col_inc == (CW+1)'(COLS));
  assign need_scroll = wrap && (row_inc == (RW+1)'(ROWS));

  assign put_pos  = AW'(row_pos) * AW'(COLS) + AW'(col_pos);
  assign read_ok  = (32'(rd_row_q) < 32'(ROWS)) && (32'(rd_col_q) < 32'(COLS));
  assign read_pos = AW'(rd_row_q) * AW'(COLS) + AW'(rd_col_q);

  assign raddr = cmd.copy_rd ? (idx + AW'(COLS)) : read_pos;

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = {tmtw_pkg::CHAR_SPACE, fill};
    if (wr_pend) begin
      we    = 1'b1;
      waddr = wr_addr;
      wdata = rdata;
    end else if (cmd.put_step) begin
      we    = !is_nl;
      waddr = put_pos;
      wdata = {char_q, attr_q};
    end else begin
      case (cmd.wsel)
        tmtw_pkg::W_FILL: we = 1'b1;
        tmtw_pkg::W_INIT: begin
          we    = 1'b1;
          wdata = {tmtw_pkg::CHAR_SPACE, tmtw_pkg::FILL_RESET};
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    status.put_scroll    = need_scroll;
    status.idx_last_copy = (idx == AW'(COPY_N - 1));
    status.idx_last_cell = (idx == AW'(CELLS - 1));
    status.out_free      = !out_valid || out_ready;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos   <= '0;
      col_pos   <= '0;
      idx       <= '0;
      wr_pend   <= 1'b0;
      fill      <= tmtw_pkg::FILL_RESET;
      out_valid <= 1'b0;
    end else begin
      wr_pend <= cmd.copy_rd;
      if (cfg_wr_en) begin
        fill <= cfg_wr_data;
      end
      if (cmd.idx_zero) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + AW'(1);
      end
      if (cmd.home) begin
        row_pos <= '0;
        col_pos <= '0;
      end else if (cmd.put_step) begin
        if (wrap) begin
          col_pos <= '0;
          row_pos <= need_scroll ? RW'(ROWS - 1) : row_inc[RW-1:0];
        end else begin
          col_pos <= col_inc[CW-1:0];
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign row_ext = 32'(row_pos);
  assign col_ext = 32'(col_pos);

  // payload registers
  always_ff @(posedge clk) begin
    wr_addr <= idx;
    if (cmd.capture) begin
      char_q     <= in_char_code;
      attr_q     <= in_attribute;
      rd_row_q   <= in_read_row;
      rd_col_q   <= in_read_col;
      scrolled_q <= 1'b0;
      cell_q     <= '0;
    end else begin
      if (cmd.put_step && need_scroll) begin
        scrolled_q <= 1'b1;
      end
      if (cmd.read_cap && read_ok) begin
        cell_q <= rdata;
      end
    end
    if (cmd.out_load) begin
      out_cursor_row     <= row_ext[tmtw_pkg::ROW_W-1:0];
      out_cursor_col     <= col_ext[tmtw_pkg::COL_W-1:0];
      out_scrolled       <= scrolled_q;
      out_cell_char      <= cell_q[tmtw_pkg::CELL_W-1:tmtw_pkg::ATTR_W];
      out_cell_attribute <= cell_q[tmtw_pkg::ATTR_W-1:0];
    end
  end

endmodule

`default_nettype wire
